[src/sadbm_pkg.sv]
// Shared constants, types and codes of the SAD stereo block matcher.
`default_nettype none
package sadbm_pkg;
    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_WINDOW    = 15;
    localparam int MAX_DISPARITY = 64;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WCOL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = 12;
    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int RMAX    = (MAX_WINDOW - 1) / 2;
    localparam int RAD_W   = $clog2(RMAX + 1);
    localparam int SPAN_W  = $clog2(MAX_WINDOW);
    localparam int D_W     = $clog2(MAX_DISPARITY);
    localparam int RANGE_W = $clog2(MAX_DISPARITY + 1);
    localparam int DEPTH   = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEVEL_MAX = 255;
    localparam int LEVEL_W = 8;
    localparam int COST_W  = $clog2(MAX_WINDOW * MAX_WINDOW * LEVEL_MAX + 1);
    localparam int NUM_W   = $clog2((MAX_DISPARITY - 1) * LEVEL_MAX + 1);
    localparam int DCNT_W  = $clog2(NUM_W + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // configuration register file
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CW_WIDTH  = 11;
    localparam int CW_HEIGHT = 12;
    localparam int CW_RANGE  = 7;
    localparam int CW_SIDE   = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 2'd3;
    localparam logic [CW_WIDTH-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [CW_HEIGHT-1:0] RST_HEIGHT = 12'd480;
    localparam logic [CW_RANGE-1:0]  RST_RANGE  = 7'd64;
    localparam logic [CW_SIDE-1:0]   RST_SIDE   = 4'd9;

    typedef struct packed {
        logic [WCOL_W-1:0]  width;
        logic [ROW_W-1:0]   height;
        logic [RANGE_W-1:0] range;
        logic [RAD_W-1:0]   radius;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  right;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] slot;
        logic              emit;
        logic              margin;
        logic              fdone;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } t_qstat;
endpackage
`default_nettype wire

[src/sadbm_if.sv]
// Stream interfaces: pixel pairs in, disparity results out.
`default_nettype none
interface sadbm_pix_if;
    logic                          valid;
    logic                          ready;
    logic [sadbm_pkg::PIX_W-1:0]   left_pixel;
    logic [sadbm_pkg::PIX_W-1:0]   right_pixel;
    modport source(output valid, left_pixel, right_pixel, input ready);
    modport sink(input valid, left_pixel, right_pixel, output ready);
endinterface

interface sadbm_disp_if;
    logic                          valid;
    logic                          ready;
    logic [sadbm_pkg::COL_W-1:0]   centre_col;
    logic [sadbm_pkg::ROW_W-1:0]   centre_row;
    logic [sadbm_pkg::LEVEL_W-1:0] disparity_level;
    logic                          frame_done;
    modport source(output valid, centre_col, centre_row, disparity_level, frame_done,
                   input ready);
    modport sink(input valid, centre_col, centre_row, disparity_level, frame_done,
                 output ready);
endinterface
`default_nettype wire

[src/sadbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sadbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/sadbm_front.sv]
// Front end: configuration registers, raster counters and item classification.
`default_nettype none
module sadbm_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sadbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sadbm_pkg::CFG_W-1:0]       i_cfg_data,
    sadbm_pix_if.sink                              i_pix,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output sadbm_pkg::t_item                       o_item,
    output sadbm_pkg::t_cfg                        o_cfg
);
    logic [sadbm_pkg::CW_WIDTH-1:0]  r_width;
    logic [sadbm_pkg::CW_HEIGHT-1:0] r_height;
    logic [sadbm_pkg::CW_RANGE-1:0]  r_range;
    logic [sadbm_pkg::CW_SIDE-1:0]   r_side;
    logic [sadbm_pkg::COL_W-1:0]     r_col;
    logic [sadbm_pkg::ROW_W-1:0]     r_row;
    logic [sadbm_pkg::SLOT_W-1:0]    r_slot;
    logic [sadbm_pkg::CW_SIDE-2:0]   half;
    logic [sadbm_pkg::RAD_W:0]       two_r;
    logic [sadbm_pkg::COL_W-1:0]     cx;
    logic                            col_end;
    logic                            row_end;

    // effective configuration after clamping
    always_comb begin
        if (r_width == '0) begin
            o_cfg.width = sadbm_pkg::WCOL_W'(1);
        end else if (r_width > sadbm_pkg::CW_WIDTH'(sadbm_pkg::MAX_WIDTH)) begin
            o_cfg.width = sadbm_pkg::WCOL_W'(sadbm_pkg::MAX_WIDTH);
        end else begin
            o_cfg.width = sadbm_pkg::WCOL_W'(r_width);
        end
        o_cfg.height = (r_height == '0) ? sadbm_pkg::ROW_W'(1) : r_height;
        if (r_range == '0) begin
            o_cfg.range = sadbm_pkg::RANGE_W'(1);
        end else if (r_range > sadbm_pkg::CW_RANGE'(sadbm_pkg::MAX_DISPARITY)) begin
            o_cfg.range = sadbm_pkg::RANGE_W'(sadbm_pkg::MAX_DISPARITY);
        end else begin
            o_cfg.range = sadbm_pkg::RANGE_W'(r_range);
        end
        half = r_side[sadbm_pkg::CW_SIDE-1:1];
        if (sadbm_pkg::RAD_W'(half) > sadbm_pkg::RAD_W'(sadbm_pkg::RMAX)) begin
            o_cfg.radius = sadbm_pkg::RAD_W'(sadbm_pkg::RMAX);
        end else begin
            o_cfg.radius = sadbm_pkg::RAD_W'(half);
        end
    end

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    always_comb begin
        two_r   = {o_cfg.radius, 1'b0};
        cx      = r_col - sadbm_pkg::COL_W'(o_cfg.radius);
        col_end = (sadbm_pkg::WCOL_W'(r_col) + sadbm_pkg::WCOL_W'(1)) >= o_cfg.width;
        row_end = ((sadbm_pkg::ROW_W+1)'(r_row) + (sadbm_pkg::ROW_W+1)'(1))
                  >= (sadbm_pkg::ROW_W+1)'(o_cfg.height);
        o_item.left   = i_pix.left_pixel;
        o_item.right  = i_pix.right_pixel;
        o_item.col    = r_col;
        o_item.row    = r_row;
        o_item.slot   = r_slot;
        o_item.emit   = (r_row >= sadbm_pkg::ROW_W'(two_r))
                     && (r_col >= sadbm_pkg::COL_W'(two_r));
        o_item.margin = (sadbm_pkg::WCOL_W'(cx)) <
                        (sadbm_pkg::WCOL_W'(o_cfg.range) + sadbm_pkg::WCOL_W'(o_cfg.radius));
        o_item.fdone  = row_end && col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sadbm_pkg::RST_WIDTH;
            r_height <= sadbm_pkg::RST_HEIGHT;
            r_range  <= sadbm_pkg::RST_RANGE;
            r_side   <= sadbm_pkg::RST_SIDE;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sadbm_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[sadbm_pkg::CW_WIDTH-1:0];
                sadbm_pkg::CFG_HEIGHT: r_height <= i_cfg_data[sadbm_pkg::CW_HEIGHT-1:0];
                sadbm_pkg::CFG_RANGE:  r_range  <= i_cfg_data[sadbm_pkg::CW_RANGE-1:0];
                sadbm_pkg::CFG_SIDE:   r_side   <= i_cfg_data[sadbm_pkg::CW_SIDE-1:0];
                default: ;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (o_push) begin
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + sadbm_pkg::ROW_W'(1);
                    r_slot <= (r_slot == sadbm_pkg::SLOT_W'(sadbm_pkg::MAX_WINDOW - 1))
                              ? '0 : r_slot + sadbm_pkg::SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + sadbm_pkg::COL_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

[src/sadbm_queue.sv]
// Short item queue between the front end and the matching engine.
`default_nettype none
module sadbm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sadbm_pkg::t_item i_item,
    input  wire logic             i_pop,
    output sadbm_pkg::t_item      o_head,
    output sadbm_pkg::t_qstat     o_stat
);
    sadbm_pkg::t_item                r_buf [sadbm_pkg::QDEPTH];
    logic [sadbm_pkg::QPTR_W-1:0]    r_wptr;
    logic [sadbm_pkg::QPTR_W-1:0]    r_rptr;
    logic [sadbm_pkg::QCNT_W-1:0]    r_count;

    assign o_head       = r_buf[r_rptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == sadbm_pkg::QCNT_W'(sadbm_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == sadbm_pkg::QPTR_W'(sadbm_pkg::QDEPTH - 1))
                          ? '0 : r_wptr + sadbm_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == sadbm_pkg::QPTR_W'(sadbm_pkg::QDEPTH - 1))
                          ? '0 : r_rptr + sadbm_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + sadbm_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - sadbm_pkg::QCNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

[src/sadbm_back.sv]
// Matching engine: line stores, SAD scan over disparities, scaling divider, result register.
`default_nettype none
module sadbm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sadbm_pkg::t_cfg  i_cfg,
    input  wire sadbm_pkg::t_item i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    sadbm_disp_if.source          o_disp
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_LOAD  = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                           r_state;
    logic [sadbm_pkg::COL_W-1:0]      r_cx;
    logic [sadbm_pkg::ROW_W-1:0]      r_cy;
    logic                             r_fd;
    logic [sadbm_pkg::COL_W-1:0]      r_lc0;
    logic [sadbm_pkg::COL_W-1:0]      r_lc;
    logic [sadbm_pkg::SLOT_W-1:0]     r_s0;
    logic [sadbm_pkg::SLOT_W-1:0]     r_slot;
    logic [sadbm_pkg::D_W-1:0]        r_d;
    logic [sadbm_pkg::SPAN_W-1:0]     r_k;
    logic [sadbm_pkg::SPAN_W-1:0]     r_i;
    logic                             r_p_vld;
    logic                             r_p_first;
    logic                             r_p_last;
    logic [sadbm_pkg::D_W-1:0]        r_p_d;
    logic [sadbm_pkg::COST_W-1:0]     r_acc;
    logic [sadbm_pkg::COST_W-1:0]     r_best;
    logic [sadbm_pkg::D_W-1:0]        r_bestd;
    logic [sadbm_pkg::NUM_W-1:0]      r_num;
    logic [sadbm_pkg::RANGE_W-1:0]    r_rem;
    logic [sadbm_pkg::DCNT_W-1:0]     r_dcnt;
    logic                             r_ovld;

    logic [sadbm_pkg::SPAN_W-1:0]     two_r;
    logic [sadbm_pkg::SLOT_W:0]       s0_wide;
    logic [sadbm_pkg::ADDR_W-1:0]     waddr;
    logic [sadbm_pkg::ADDR_W-1:0]     raddr_l;
    logic [sadbm_pkg::ADDR_W-1:0]     raddr_r;
    logic [sadbm_pkg::PIX_W-1:0]      rdata_l;
    logic [sadbm_pkg::PIX_W-1:0]      rdata_r;
    logic [sadbm_pkg::PIX_W-1:0]      diff;
    logic [sadbm_pkg::COST_W-1:0]     sum;
    logic [sadbm_pkg::RANGE_W:0]      trial;
    logic                             trial_ge;
    logic                             i_end;
    logic                             k_end;
    logic                             d_end;
    logic                             out_free;
    logic                             load_out;

    assign two_r    = sadbm_pkg::SPAN_W'({i_cfg.radius, 1'b0});
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_ovld || o_disp.ready;
    assign load_out = (r_state == S_OUT) && out_free;
    assign i_end    = (r_i == two_r);
    assign k_end    = (r_k == two_r);
    assign d_end    = (sadbm_pkg::RANGE_W'(r_d) == i_cfg.range - sadbm_pkg::RANGE_W'(1));

    // oldest window row slot, wrapped into the line store ring
    assign s0_wide = ((sadbm_pkg::SLOT_W+1)'(i_head.slot) >= (sadbm_pkg::SLOT_W+1)'(two_r))
        ? (sadbm_pkg::SLOT_W+1)'(i_head.slot) - (sadbm_pkg::SLOT_W+1)'(two_r)
        : (sadbm_pkg::SLOT_W+1)'(i_head.slot) + (sadbm_pkg::SLOT_W+1)'(sadbm_pkg::MAX_WINDOW)
          - (sadbm_pkg::SLOT_W+1)'(two_r);

    assign waddr   = sadbm_pkg::ADDR_W'(i_head.slot) * sadbm_pkg::ADDR_W'(sadbm_pkg::MAX_WIDTH)
                   + sadbm_pkg::ADDR_W'(i_head.col);
    assign raddr_l = sadbm_pkg::ADDR_W'(r_slot) * sadbm_pkg::ADDR_W'(sadbm_pkg::MAX_WIDTH)
                   + sadbm_pkg::ADDR_W'(r_lc);
    assign raddr_r = sadbm_pkg::ADDR_W'(r_slot) * sadbm_pkg::ADDR_W'(sadbm_pkg::MAX_WIDTH)
                   + sadbm_pkg::ADDR_W'(r_lc - sadbm_pkg::COL_W'(r_d));

    sadbm_ram #(.WIDTH(sadbm_pkg::PIX_W), .DEPTH(sadbm_pkg::DEPTH)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (waddr),
        .i_wdata (i_head.left),
        .i_raddr (raddr_l),
        .o_rdata (rdata_l)
    );

    sadbm_ram #(.WIDTH(sadbm_pkg::PIX_W), .DEPTH(sadbm_pkg::DEPTH)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (waddr),
        .i_wdata (i_head.right),
        .i_raddr (raddr_r),
        .o_rdata (rdata_r)
    );

    always_comb begin
        diff     = (rdata_l > rdata_r) ? rdata_l - rdata_r : rdata_r - rdata_l;
        sum      = (r_p_first ? '0 : r_acc) + sadbm_pkg::COST_W'(diff);
        trial    = {r_rem, r_num[sadbm_pkg::NUM_W-1]};
        trial_ge = trial >= (sadbm_pkg::RANGE_W+1)'(i_cfg.range);
    end

    // cost accumulation, one pixel pair a cycle
    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc <= sum;
            if (r_p_last && ((r_p_d == '0) || (sum < r_best))) begin
                r_best  <= sum;
                r_bestd <= r_p_d;
            end
        end
    end

    // address sequencing and divider datapath
    always_ff @(posedge i_clk) begin
        r_p_first <= (r_k == '0) && (r_i == '0);
        r_p_last  <= k_end && i_end;
        r_p_d     <= r_d;
        unique case (r_state)
            S_IDLE: begin
                r_cx  <= i_head.col - sadbm_pkg::COL_W'(i_cfg.radius);
                r_cy  <= i_head.row - sadbm_pkg::ROW_W'(i_cfg.radius);
                r_fd  <= i_head.fdone;
                r_lc0 <= i_head.col - sadbm_pkg::COL_W'(two_r);
                r_lc  <= i_head.col - sadbm_pkg::COL_W'(two_r);
                r_s0  <= sadbm_pkg::SLOT_W'(s0_wide);
                r_slot <= sadbm_pkg::SLOT_W'(s0_wide);
                r_d   <= '0;
                r_k   <= '0;
                r_i   <= '0;
                r_num <= '0;
            end
            S_SCAN: begin
                if (i_end) begin
                    r_i  <= '0;
                    r_lc <= r_lc0;
                    if (k_end) begin
                        r_k    <= '0;
                        r_slot <= r_s0;
                        r_d    <= r_d + sadbm_pkg::D_W'(1);
                    end else begin
                        r_k    <= r_k + sadbm_pkg::SPAN_W'(1);
                        r_slot <= (r_slot == sadbm_pkg::SLOT_W'(sadbm_pkg::MAX_WINDOW - 1))
                                  ? '0 : r_slot + sadbm_pkg::SLOT_W'(1);
                    end
                end else begin
                    r_i  <= r_i + sadbm_pkg::SPAN_W'(1);
                    r_lc <= r_lc + sadbm_pkg::COL_W'(1);
                end
            end
            S_DRAIN: ;
            S_LOAD: begin
                // d*255 as d*256 - d
                r_num  <= (sadbm_pkg::NUM_W'(r_bestd) << 8) - sadbm_pkg::NUM_W'(r_bestd);
                r_rem  <= '0;
                r_dcnt <= sadbm_pkg::DCNT_W'(sadbm_pkg::NUM_W);
            end
            S_DIV: begin
                r_rem  <= trial_ge
                          ? sadbm_pkg::RANGE_W'(trial - (sadbm_pkg::RANGE_W+1)'(i_cfg.range))
                          : sadbm_pkg::RANGE_W'(trial);
                r_num  <= {r_num[sadbm_pkg::NUM_W-2:0], trial_ge};
                r_dcnt <= r_dcnt - sadbm_pkg::DCNT_W'(1);
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p_vld <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_p_vld <= (r_state == S_SCAN);
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (o_disp.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_head.emit) begin
                        r_state <= i_head.margin ? S_OUT : S_SCAN;
                    end
                end
                S_SCAN:  if (i_end && k_end && d_end) r_state <= S_DRAIN;
                S_DRAIN: r_state <= S_LOAD;
                S_LOAD:  r_state <= S_DIV;
                S_DIV:   if (r_dcnt == sadbm_pkg::DCNT_W'(1)) r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_disp.centre_col      <= r_cx;
            o_disp.centre_row      <= r_cy;
            o_disp.disparity_level <= r_num[sadbm_pkg::LEVEL_W-1:0];
            o_disp.frame_done      <= r_fd;
        end
    end

    assign o_disp.valid = r_ovld;
endmodule
`default_nettype wire

[src/stereo_sad_block_match_core.sv]
// Top level of the SAD stereo block matcher.
`default_nettype none
// Left and right pixels arrive as one item per raster position. The front end
// takes an item whenever its two-entry queue has room, tags it with its row,
// column and line-store slot and decides whether it completes a window. The
// matching engine then writes the pair into the line stores (one RAM per image,
// fifteen rows deep) and, for a complete window away from the left margin,
// walks every disparity and every window pixel, one pixel pair per cycle from
// a single read port on each store, keeping the lowest sum (smaller disparity
// on ties). The winner is scaled by d*255/range in a bit-serial divider.
// Cost of one item: the pair is written in the idle state, which ends the work
// when no result is due; a centre in the left margin goes straight to the result
// stage; otherwise the scan, a drain step, the divider load and the divide run first. The result
// register lets the next item proceed while a result waits. Configuration
// writes restart the frame and must only be made while the block is idle.
module stereo_sad_block_match_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sadbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sadbm_pkg::CFG_W-1:0]     i_cfg_data,
    sadbm_pix_if.sink                            i_pix,
    sadbm_disp_if.source                         o_disp
);
    sadbm_pkg::t_cfg   cfg;
    sadbm_pkg::t_item  push_item;
    sadbm_pkg::t_item  head_item;
    sadbm_pkg::t_qstat qstat;
    logic              push;
    logic              pop;

    // classify items, hold configuration
    sadbm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_full     (qstat.full),
        .o_push     (push),
        .o_item     (push_item),
        .o_cfg      (cfg)
    );

    // decouple the two sides
    sadbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (qstat)
    );

    // store, match and scale
    sadbm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_head  (head_item),
        .i_empty (qstat.empty),
        .o_pop   (pop),
        .o_disp  (o_disp)
    );

    // the engine only takes an item that is really queued
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("item taken from empty queue");

    // occupancy drops by one on a pop without a push
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (qstat.count == $past(qstat.count) - sadbm_pkg::QCNT_W'(1)))
        else $error("queue count lost an item");

    // nothing is presented right after reset
    a_out_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_disp.valid)
        else $error("result valid after reset");
endmodule
`default_nettype wire
